>>> rtl/pretrade_risk_position_keeper_unit_defines.svh
// assertion macros shared by the rtl
`ifndef PRETRADE_RISK_POSITION_KEEPER_UNIT_DEFINES_SVH
`define PRETRADE_RISK_POSITION_KEEPER_UNIT_DEFINES_SVH

// same-cycle implication
`define PRK_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PRK_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/prk_pkg.sv
package prk_pkg;
  localparam int SYM_W       = 4;
  localparam int NUM_SYMBOLS = 2 ** SYM_W;
  localparam int QTY_W       = 20;
  localparam int PRICE_W     = 32;
  localparam int PROFIT_W    = 63;
  localparam int CASH_W      = 62;
  localparam int OPEN_W      = 53;
  localparam int DIVD_W      = 53;
  localparam int STAT_W      = 3;

  localparam logic [STAT_W-1:0] ST_FILLED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_CASH   = 3'd2;
  localparam logic [STAT_W-1:0] ST_POS_LIMIT = 3'd3;
  localparam logic [STAT_W-1:0] ST_SHORT     = 3'd4;

  localparam logic CFG_MAX_ORDER = 1'b0;
  localparam logic CFG_MAX_POS   = 1'b1;

  localparam logic [QTY_W-1:0]  MAX_ORDER_RST = 20'd100;
  localparam logic [QTY_W-1:0]  MAX_POS_RST   = 20'd1000;
  localparam logic [CASH_W-1:0] CASH_RST      = 62'd1000000000;

  typedef logic [QTY_W-1:0] qty_t;
endpackage

>>> rtl/pretrade_risk_position_keeper_unit.sv
// channel | ports                                   | handshake
// input   | in_sell_side in_symbol_index in_order_quantity in_market_price | start & !busy
// result  | out_status out_held_quantity out_mean_cost out_booked_profit
//         | out_cash_left out_open_profit           | out_valid, one cycle
// config  | cfg_we cfg_index cfg_wdata              | cfg_we
// a filled buy whose resulting holding is nonzero runs the 53-step restoring divider
// for the average price (S_BUYSUM, S_DIV, S_BUYWB, S_OPEN); a filled sell runs
// S_SELL, a zero buy on an empty holding skips S_DIV, a rejected item goes from S_CHECK to S_OPEN.
// one shared 33x21 multiplier serves order value, cost basis, pnl and open pnl.
// rst_n is synchronous; it clears all tables and reloads cash and limits with their reset values at once.
// the receiver cannot stall: out_valid lasts one cycle, start is taken again
// once busy falls.
module pretrade_risk_position_keeper_unit
  import prk_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_sell_side,
  input  logic [SYM_W-1:0]           in_symbol_index,
  input  logic [QTY_W-1:0]           in_order_quantity,
  input  logic [PRICE_W-1:0]         in_market_price,
  output logic                       out_valid,
  output logic [STAT_W-1:0]          out_status,
  output logic [QTY_W-1:0]           out_held_quantity,
  output logic [PRICE_W-1:0]         out_mean_cost,
  output logic signed [PROFIT_W-1:0] out_booked_profit,
  output logic [CASH_W-1:0]          out_cash_left,
  output logic signed [OPEN_W-1:0]   out_open_profit,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [QTY_W-1:0]           cfg_wdata
);
`include "pretrade_risk_position_keeper_unit_defines.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_BUYSUM = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_BUYWB  = 4'd5;
  localparam logic [3:0] S_SELL   = 4'd6;
  localparam logic [3:0] S_OPEN   = 4'd7;

  logic [3:0] state_r, state_nxt;

  qty_t                       max_order_r, max_pos_r;
  qty_t                       hold_tab_r [NUM_SYMBOLS];
  logic [PRICE_W-1:0]         avg_tab_r  [NUM_SYMBOLS];
  logic signed [PROFIT_W-1:0] prof_tab_r [NUM_SYMBOLS];
  logic [CASH_W-1:0]          cash_r;

  logic                       sell_r;
  logic [SYM_W-1:0]           sym_r;
  qty_t                       qty_r, held_r;
  logic [PRICE_W-1:0]         price_r, avg_r;
  logic signed [PROFIT_W-1:0] prof_r;
  logic [51:0]                value_r;
  logic signed [53:0]         mprod_r;
  logic [STAT_W-1:0]          status_r;
  logic [DIVD_W-1:0]          quo_r;
  logic [20:0]                rem_r, total_r;
  logic [5:0]                 cnt_r;
  logic                       out_valid_r;

  // shared multiplier
  logic signed [32:0] mul_a;
  qty_t               mul_b;
  logic signed [53:0] mul_p;

  always_comb begin
    mul_a = $signed({1'b0, price_r});
    mul_b = qty_r;
    case (state_r)
      S_LOAD:  begin mul_a = $signed({1'b0, price_r}); mul_b = qty_r; end
      S_CHECK: begin
        if (sell_r) begin
          mul_a = $signed({1'b0, price_r}) - $signed({1'b0, avg_r});
          mul_b = qty_r;
        end else begin
          mul_a = $signed({1'b0, avg_r});
          mul_b = held_r;
        end
      end
      S_OPEN:  begin
        mul_a = $signed({1'b0, price_r}) - $signed({1'b0, avg_r});
        mul_b = held_r;
      end
      default: begin mul_a = $signed({1'b0, price_r}); mul_b = qty_r; end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // checks
  logic [20:0]       mag;
  logic [STAT_W-1:0] status_c;

  always_comb begin
    if (!sell_r) mag = {1'b0, held_r} + {1'b0, qty_r};
    else if (held_r >= qty_r) mag = {1'b0, held_r - qty_r};
    else mag = {1'b0, qty_r - held_r};
    if (qty_r > max_order_r) status_c = ST_TOO_LARGE;
    else if (!sell_r && ({10'd0, value_r} > cash_r)) status_c = ST_NO_CASH;
    else if (mag > {1'b0, max_pos_r}) status_c = ST_POS_LIMIT;
    else if (sell_r && (qty_r > held_r)) status_c = ST_SHORT;
    else status_c = ST_FILLED;
  end

  // divider step
  logic [21:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, total_r};

  // sell sums
  logic signed [63:0] prof_sum;
  logic [62:0]        cash_sum;
  assign prof_sum = {prof_r[PROFIT_W-1], prof_r} + {{10{mprod_r[53]}}, mprod_r};
  assign cash_sum = {1'b0, cash_r} + {11'd0, value_r};

  logic [DIVD_W-1:0] dividend;
  assign dividend = mprod_r[DIVD_W-1:0] + {1'b0, value_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_CHECK;
      S_CHECK:  begin
        if (status_c != ST_FILLED) state_nxt = S_OPEN;
        else if (sell_r) state_nxt = S_SELL;
        else state_nxt = S_BUYSUM;
      end
      S_BUYSUM: state_nxt = (({1'b0, held_r} + {1'b0, qty_r}) == 21'd0) ? S_OPEN : S_DIV;
      S_DIV:    if (cnt_r == 6'd1) state_nxt = S_BUYWB;
      S_BUYWB:  state_nxt = S_OPEN;
      S_SELL:   state_nxt = S_OPEN;
      S_OPEN:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_order_r <= MAX_ORDER_RST;
      max_pos_r   <= MAX_POS_RST;
      cash_r      <= CASH_RST;
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        hold_tab_r[i] <= '0;
        avg_tab_r[i]  <= '0;
        prof_tab_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_ORDER) max_order_r <= cfg_wdata;
        else max_pos_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            sell_r  <= in_sell_side;
            sym_r   <= in_symbol_index;
            qty_r   <= in_order_quantity;
            price_r <= in_market_price;
          end
        end
        S_LOAD: begin
          held_r  <= hold_tab_r[sym_r];
          avg_r   <= avg_tab_r[sym_r];
          prof_r  <= prof_tab_r[sym_r];
          value_r <= mul_p[51:0];
        end
        S_CHECK: begin
          status_r <= status_c;
          mprod_r  <= mul_p;
        end
        S_BUYSUM: begin
          cash_r  <= cash_r - {10'd0, value_r};
          total_r <= {1'b0, held_r} + {1'b0, qty_r};
          held_r  <= held_r + qty_r;
          quo_r   <= dividend;
          rem_r   <= '0;
          cnt_r   <= 6'(DIVD_W);
        end
        S_DIV: begin
          quo_r <= {quo_r[DIVD_W-2:0], rem_ge};
          rem_r <= rem_ge ? 21'(rem_sh - {1'b0, total_r}) : rem_sh[20:0];
          cnt_r <= cnt_r - 6'd1;
        end
        S_BUYWB: avg_r <= quo_r[PRICE_W-1:0];
        S_SELL: begin
          cash_r <= cash_sum[62] ? {CASH_W{1'b1}} : cash_sum[CASH_W-1:0];
          if (held_r != '0) begin
            if (prof_sum[63] != prof_sum[62])
              prof_r <= prof_sum[63] ? {1'b1, {(PROFIT_W-1){1'b0}}}
                                     : {1'b0, {(PROFIT_W-1){1'b1}}};
            else prof_r <= prof_sum[PROFIT_W-1:0];
          end
          held_r <= held_r - qty_r;
          if (held_r == qty_r) avg_r <= '0;
        end
        S_OPEN: begin
          hold_tab_r[sym_r] <= held_r;
          avg_tab_r[sym_r]  <= avg_r;
          prof_tab_r[sym_r] <= prof_r;
          out_valid_r       <= 1'b1;
          out_status        <= status_r;
          out_held_quantity <= held_r;
          out_mean_cost     <= avg_r;
          out_booked_profit <= prof_r;
          out_cash_left     <= cash_r;
          out_open_profit   <= mul_p[OPEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  `PRK_AST_NXT(a_strobe_single, out_valid, !out_valid)
  `PRK_AST_NXT(a_start_busy, start && !busy, busy)
  `PRK_AST_NOW(a_div_count, state_r == S_DIV, cnt_r != 6'd0)
  `PRK_AST_NOW(a_status_code, out_valid, out_status <= ST_SHORT)
endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import prk_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_sell_side = 1'b0;
  logic [SYM_W-1:0]           in_symbol_index = '0;
  logic [QTY_W-1:0]           in_order_quantity = '0;
  logic [PRICE_W-1:0]         in_market_price = '0;
  logic                       out_valid;
  logic [STAT_W-1:0]          out_status;
  logic [QTY_W-1:0]           out_held_quantity;
  logic [PRICE_W-1:0]         out_mean_cost;
  logic signed [PROFIT_W-1:0] out_booked_profit;
  logic [CASH_W-1:0]          out_cash_left;
  logic signed [OPEN_W-1:0]   out_open_profit;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = CFG_MAX_ORDER;
  logic [QTY_W-1:0]           cfg_wdata = '0;

  typedef struct packed {
    logic [STAT_W-1:0]          status;
    logic [QTY_W-1:0]           held;
    logic [PRICE_W-1:0]         avg;
    logic signed [PROFIT_W-1:0] profit;
    logic [CASH_W-1:0]          cash;
    logic signed [OPEN_W-1:0]   open_pnl;
  } fill_report_t;

  localparam longint CASH_CAP   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint PROFIT_TOP = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint PROFIT_BOT = -PROFIT_TOP - 1;
  localparam int     CYCLE_LIMIT = 2000000;

  pretrade_risk_position_keeper_unit DUT (.*);

  always #4 clk = ~clk;

  fill_report_t report_q[$];
  longint unsigned lim_order, lim_pos, cash_bal;
  longint unsigned hold_tbl[NUM_SYMBOLS];
  longint unsigned avg_tbl[NUM_SYMBOLS];
  longint          pnl_tbl[NUM_SYMBOLS];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 0;

  function automatic fill_report_t risk_book(bit sell, int sym, longint unsigned qty,
                                             longint unsigned price);
    fill_report_t r;
    longint unsigned held, value, total, avg;
    longint resulting, mag, pnl, s, openp;
    logic [STAT_W-1:0] st;
    held = hold_tbl[sym];
    value = price * qty;
    resulting = sell ? longint'(held) - longint'(qty) : longint'(held) + longint'(qty);
    mag = resulting < 0 ? -resulting : resulting;
    st = ST_FILLED;
    if (qty > lim_order) st = ST_TOO_LARGE;
    else if (!sell && value > cash_bal) st = ST_NO_CASH;
    else if (mag > longint'(lim_pos)) st = ST_POS_LIMIT;
    else if (sell && resulting < 0) st = ST_SHORT;
    if (st == ST_FILLED) begin
      avg = avg_tbl[sym];
      if (!sell) begin
        total = held + qty;
        cash_bal -= value;
        if (total > 0) avg_tbl[sym] = ((avg * held + value) / total) & 64'hFFFF_FFFF;
        hold_tbl[sym] = total & 64'hF_FFFF;
      end else begin
        cash_bal = (cash_bal + value > CASH_CAP) ? CASH_CAP : cash_bal + value;
        if (held > 0) begin
          pnl = (longint'(price) - longint'(avg)) * longint'(qty);
          s = pnl_tbl[sym] + pnl;
          pnl_tbl[sym] = s > PROFIT_TOP ? PROFIT_TOP : (s < PROFIT_BOT ? PROFIT_BOT : s);
        end
        hold_tbl[sym] = (held - qty) & 64'hF_FFFF;
        if (hold_tbl[sym] == 0) avg_tbl[sym] = 0;
      end
    end
    held = hold_tbl[sym];
    openp = held == 0 ? 0 : (longint'(price) - longint'(avg_tbl[sym])) * longint'(held);
    r.status = st;
    r.held = held[QTY_W-1:0];
    r.avg = avg_tbl[sym][PRICE_W-1:0];
    r.profit = pnl_tbl[sym][PROFIT_W-1:0];
    r.cash = cash_bal[CASH_W-1:0];
    r.open_pnl = openp[OPEN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    fill_report_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_held_quantity, out_mean_cost, out_booked_profit,
              out_cash_left, out_open_profit};
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = report_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d hq=%0d mc=%0d bp=%0d cl=%0d op=%0d / got st=%0d hq=%0d mc=%0d bp=%0d cl=%0d op=%0d",
                     want.status, want.held, want.avg, want.profit, want.cash, want.open_pnl,
                     got.status, got.held, got.avg, got.profit, got.cash, got.open_pnl);
        end
      end
    end
  end

  task automatic send_order(bit sell, logic [SYM_W-1:0] sym, logic [QTY_W-1:0] qty,
                            logic [PRICE_W-1:0] price);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    in_sell_side <= sell;
    in_symbol_index <= sym;
    in_order_quantity <= qty;
    in_market_price <= price;
    @(posedge clk);
    while (busy) @(posedge clk);
    report_q.push_back(risk_book(sell, int'(sym), 64'(qty), 64'(price)));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (report_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [QTY_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ORDER) lim_order = 64'(val);
    else lim_pos = 64'(val);
  endtask

  task automatic test_directed;
    send_order(0, 0, 0, 0);
    send_order(1, 0, 0, 32'hFFFF_FFFF);
    send_order(0, 1, 100, 1000000);
    send_order(0, 1, 101, 10);
    send_order(0, 2, 50, 32'hFFFF_FFFF);
    send_order(0, 1, 50, 2000000);
    send_order(1, 1, 30, 32'hFFFF_FFFF);
    send_order(1, 1, 120, 5);
    send_order(1, 3, 5, 100);
    send_order(1, 1, 100, 1);
    send_order(0, 1, 0, 7);
    write_limit(CFG_MAX_POS, 20'd10);
    send_order(1, 4, 11, 100);
    send_order(0, 4, 11, 100);
    send_order(0, 4, 10, 100);
    write_limit(CFG_MAX_ORDER, 20'hF_FFFF);
    write_limit(CFG_MAX_POS, 20'hF_FFFF);
    send_order(0, 5, 20'hF_FFFF, 1);
    send_order(1, 5, 20'hF_FFFF, 32'hFFFF_FFFF);
    send_order(1, 6, 20'hF_FFFF, 0);
    write_limit(CFG_MAX_ORDER, 20'd0);
    send_order(0, 7, 1, 1);
    send_order(0, 7, 0, 1);
    write_limit(CFG_MAX_POS, 20'd0);
    send_order(0, 8, 0, 9);
    send_order(1, 8, 1, 9);
  endtask

  task automatic test_random(int n, int pct);
    bit sell;
    logic [SYM_W-1:0] sym;
    logic [QTY_W-1:0] qty;
    logic [PRICE_W-1:0] price;
    gap_pct = pct;
    repeat (n) begin
      sell = 1'($urandom_range(1));
      sym = SYM_W'($urandom_range(15));
      case ($urandom_range(9))
        0: qty = QTY_W'($urandom);
        1: qty = QTY_W'(lim_order + $urandom_range(2) - 1);
        default: qty = QTY_W'($urandom_range(lim_order > 300 ? 300 : 32'(lim_order)));
      endcase
      case ($urandom_range(7))
        0: price = $urandom;
        1: price = 32'hFFFF_FFFF - $urandom_range(3);
        default: price = $urandom_range(5000000, 10);
      endcase
      send_order(sell, sym, qty, price);
    end
  endtask

  initial begin
    lim_order = 64'(MAX_ORDER_RST);
    lim_pos = 64'(MAX_POS_RST);
    cash_bal = 64'(CASH_RST);
    foreach (hold_tbl[i]) begin
      hold_tbl[i] = 0;
      avg_tbl[i] = 0;
      pnl_tbl[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 11;
    test_directed();
    write_limit(CFG_MAX_ORDER, 20'd100);
    write_limit(CFG_MAX_POS, 20'd1000);
    test_random(600, 11);
    write_limit(CFG_MAX_ORDER, 20'd300);
    write_limit(CFG_MAX_POS, 20'd400);
    test_random(600, 57);
    write_limit(CFG_MAX_ORDER, 20'hF_FFFF);
    write_limit(CFG_MAX_POS, 20'hF_FFFF);
    test_random(500, 0);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
